[hdl/svca_pkg.sv]
`default_nettype none

package svca_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int CH_W = $clog2(MAX_CHANNELS);
  localparam int CHAN_CAP = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
  localparam int RESET_CHANNELS = (CHAN_CAP < 8) ? CHAN_CAP : 8;

  localparam int SOUND_W = 9;
  localparam int ORIGIN_W = 16;
  localparam int PRIO_W = 8;
  localparam int ENTRY_W = SOUND_W + ORIGIN_W + PRIO_W;

  typedef enum logic [1:0] {
    REQ_START       = 2'd0,
    REQ_STOP_ORIGIN = 2'd1,
    REQ_FREE        = 2'd2,
    REQ_STOP_ALL    = 2'd3
  } req_t;

  typedef struct packed {
    logic            once_hit;
    logic            org_found;
    logic [CH_W-1:0] org_idx;
    logic            free_found;
    logic [CH_W-1:0] free_idx;
    logic            ev_found;
    logic [CH_W-1:0] ev_idx;
  } scan_result_t;

endpackage

`default_nettype wire

[hdl/sound_voice_channel_allocator.sv]
// Voice channel allocator. A request is taken when start is high and busy is low.
// Stop-all, free-channel and silent start requests finish at once and their result
// appears in the next cycle. A start or stop-by-origin request scans the channel
// table in its memory at one entry per cycle, then goes through a wait and a commit
// state. Each request gives exactly one result, shown for one cycle while
// result_valid is high; the receiver cannot stall, so it must take every result
// in that cycle. Writing cfg_data frees every channel.
`default_nettype none

module sound_voice_channel_allocator import svca_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [SOUND_W-1:0]  sound_id,
  input  logic [ORIGIN_W-1:0] origin_id,
  input  logic [PRIO_W-1:0]   priority_req,
  input  logic                once_only,
  input  logic [5:0]          channel_index,
  input  logic                cfg_write,
  input  logic [6:0]          cfg_data,
  output logic                result_valid,
  output logic                granted,
  output logic [5:0]          assigned_channel,
  output logic                first_stop_valid,
  output logic [5:0]          first_stop_channel,
  output logic                second_stop_valid,
  output logic [5:0]          second_stop_channel
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  function automatic logic [6:0] limit_channels(input logic [6:0] v);
    logic [6:0] n;
    n = {v[6:2], 2'b00};
    if (n < 7'd4) n = 7'd4;
    if (n > 7'(CHAN_CAP)) n = 7'(CHAN_CAP);
    return n;
  endfunction

  function automatic logic [5:0] to_chan(input logic [CH_W-1:0] i);
    logic [CH_W+5:0] t;
    t = {{6{1'b0}}, i};
    return t[5:0];
  endfunction

  function automatic logic [CH_W-1:0] to_idx(input logic [5:0] c);
    logic [CH_W+5:0] t;
    t = {{CH_W{1'b0}}, c};
    return t[CH_W-1:0];
  endfunction

  function automatic logic idx_below(input logic [CH_W-1:0] a, input logic [6:0] b);
    return {{7{1'b0}}, a} < {{CH_W{1'b0}}, b};
  endfunction

  function automatic logic idx_is(input logic [CH_W-1:0] a, input logic [6:0] b);
    return {{7{1'b0}}, a} == {{CH_W{1'b0}}, b};
  endfunction

  state_t              state;
  logic [6:0]          active_channels;
  logic [MAX_CHANNELS-1:0] chan_busy;
  logic [CH_W-1:0]     cnt;
  logic [CH_W-1:0]     idx_d;
  logic                dvalid;
  logic [1:0]          req_q;
  logic [SOUND_W-1:0]  sound_q;
  logic [ORIGIN_W-1:0] origin_q;
  logic [PRIO_W-1:0]   prio_q;
  logic                once_q;

  logic                accept;
  logic                needs_scan;
  logic                free_ok;
  logic [CH_W-1:0]     free_sel;
  logic [ENTRY_W-1:0]  rdata;
  scan_result_t        sr;

  logic                alloc_ok;
  logic [CH_W-1:0]     alloc_idx;
  logic                stop1_ok;
  logic                stop2_ok;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign needs_scan = (req_type == REQ_STOP_ORIGIN) ||
                      ((req_type == REQ_START) && (sound_id != '0));
  assign free_sel = to_idx(channel_index);
  assign free_ok = ({1'b0, channel_index} < active_channels) && chan_busy[free_sel];

  svca_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    ((state == ST_COMMIT) && alloc_ok),
    .waddr (alloc_idx),
    .wdata ({sound_q, origin_q, prio_q}),
    .raddr (cnt),
    .rdata (rdata)
  );

  svca_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .clear        (accept && needs_scan),
    .dvalid       (dvalid),
    .idx          (idx_d),
    .entry_busy   (chan_busy[idx_d]),
    .entry_sound  (rdata[ENTRY_W-1 -: SOUND_W]),
    .entry_origin (rdata[PRIO_W +: ORIGIN_W]),
    .entry_prio   (rdata[PRIO_W-1:0]),
    .req_sound    (sound_q),
    .req_origin   (origin_q),
    .req_prio     (prio_q),
    .res          (sr)
  );

  always_comb begin
    alloc_ok = 1'b0;
    alloc_idx = sr.free_idx;
    stop1_ok = 1'b0;
    stop2_ok = 1'b0;
    if (req_q == REQ_STOP_ORIGIN) begin
      stop1_ok = sr.org_found;
    end else if (!(once_q && sr.once_hit)) begin
      stop1_ok = sr.org_found;
      if (sr.org_found) begin
        alloc_ok = 1'b1;
        if (!(sr.free_found && (sr.free_idx < sr.org_idx))) begin
          alloc_idx = sr.org_idx;
        end
      end else if (sr.free_found) begin
        alloc_ok = 1'b1;
      end else if (sr.ev_found) begin
        alloc_ok = 1'b1;
        stop2_ok = 1'b1;
        alloc_idx = sr.ev_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active_channels <= 7'(RESET_CHANNELS);
      chan_busy <= '0;
      dvalid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      dvalid <= (state == ST_SCAN);
      result_valid <= 1'b0;
      if (cfg_write) begin
        active_channels <= limit_channels(cfg_data);
        chan_busy <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (needs_scan) begin
              state <= ST_SCAN;
            end else begin
              result_valid <= 1'b1;
              if (req_type == REQ_STOP_ALL) begin
                chan_busy <= '0;
              end else if ((req_type == REQ_FREE) && free_ok) begin
                chan_busy[free_sel] <= 1'b0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (idx_is(cnt, active_channels - 7'd1)) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state <= ST_IDLE;
          result_valid <= 1'b1;
          if (stop1_ok) begin
            chan_busy[sr.org_idx] <= 1'b0;
          end
          if (stop2_ok) begin
            chan_busy[sr.ev_idx] <= 1'b0;
          end
          if (alloc_ok) begin
            chan_busy[alloc_idx] <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= cnt;
    if (accept) begin
      cnt <= '0;
      req_q <= req_type;
      sound_q <= sound_id;
      origin_q <= origin_id;
      prio_q <= priority_req;
      once_q <= once_only;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept && !needs_scan) begin
      granted <= 1'b0;
      assigned_channel <= '0;
      second_stop_valid <= 1'b0;
      second_stop_channel <= '0;
      first_stop_valid <= (req_type == REQ_FREE) && free_ok;
      first_stop_channel <= ((req_type == REQ_FREE) && free_ok) ? channel_index : 6'd0;
    end else if (state == ST_COMMIT) begin
      granted <= alloc_ok;
      assigned_channel <= alloc_ok ? to_chan(alloc_idx) : 6'd0;
      first_stop_valid <= stop1_ok;
      first_stop_channel <= stop1_ok ? to_chan(sr.org_idx) : 6'd0;
      second_stop_valid <= stop2_ok;
      second_stop_channel <= stop2_ok ? to_chan(sr.ev_idx) : 6'd0;
    end
  end

  a_grant_marks_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && granted |-> chan_busy[to_idx(assigned_channel)])
    else $error("granted channel is not marked busy");

  a_evict_needs_grant: assert property (@(posedge clk) disable iff (rst)
    result_valid && second_stop_valid |-> granted)
    else $error("eviction without a grant");

  a_single_stop_path: assert property (@(posedge clk) disable iff (rst)
    result_valid && first_stop_valid |-> !second_stop_valid)
    else $error("origin stop and eviction in one transfer");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> idx_below(cnt, active_channels))
    else $error("scan address beyond the active channels");

endmodule

`default_nettype wire

[hdl/svca_ram.sv]
`default_nettype none

module svca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/svca_scan.sv]
`default_nettype none

module svca_scan import svca_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                dvalid,
  input  logic [CH_W-1:0]     idx,
  input  logic                entry_busy,
  input  logic [SOUND_W-1:0]  entry_sound,
  input  logic [ORIGIN_W-1:0] entry_origin,
  input  logic [PRIO_W-1:0]   entry_prio,
  input  logic [SOUND_W-1:0]  req_sound,
  input  logic [ORIGIN_W-1:0] req_origin,
  input  logic [PRIO_W-1:0]   req_prio,
  output scan_result_t        res
);

  logic origin_hit;

  assign origin_hit = entry_busy && (entry_origin == req_origin);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.once_hit <= 1'b0;
      res.org_found <= 1'b0;
      res.free_found <= 1'b0;
      res.ev_found <= 1'b0;
    end else if (dvalid) begin
      if (origin_hit && (entry_sound == req_sound)) begin
        res.once_hit <= 1'b1;
      end
      if (!res.org_found && origin_hit) begin
        res.org_found <= 1'b1;
        res.org_idx <= idx;
      end
      if (!res.free_found && !entry_busy) begin
        res.free_found <= 1'b1;
        res.free_idx <= idx;
      end
      if (!res.ev_found && (entry_prio >= req_prio)) begin
        res.ev_found <= 1'b1;
        res.ev_idx <= idx;
      end
    end
  end

endmodule

`default_nettype wire
